// ----- hw/rtl/prr_pkg.sv -----
// Shared types and constants of the peak RR interval detector.
`default_nettype none

package prr_pkg;

  localparam int TIME_W    = 31;
  localparam int LEVEL_W   = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;
  localparam int RR_W      = 32;
  localparam int PIDX_W    = 5;
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 2;
  localparam int SCALED_W  = 27;

  localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 1'd1;

  localparam logic [CFG_W-1:0]          REFRACTORY_RESET = 16'd50;
  localparam logic signed [LEVEL_W-1:0] THRESHOLD_RESET  = 16'sd1229;

  localparam logic signed [SCALED_W-1:0] RISE_NUM = 27'sd1000;
  localparam logic signed [SCALED_W-1:0] RISE_DEN = 27'sd1001;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] level;
    logic [TIME_W-1:0]         tstamp;
  } win_entry_t;

endpackage

`default_nettype wire

// ----- hw/rtl/prr_win_ram.sv -----
// Window sample memory with one write port and one registered read port.
`default_nettype none

module prr_win_ram
  import prr_pkg::*;
#(
  parameter int DEPTH = 10,
  parameter int AW    = 4
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire win_entry_t    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output win_entry_t         rd_data_r
);

  win_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/prr_rise_scan.sv -----
// Rising-edge search over the window entries as they stream out of memory.
`default_nettype none

module prr_rise_scan
  import prr_pkg::*;
#(
  parameter int IDXW = 4
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic            rd_valid,
  input  wire logic [IDXW-1:0] rd_idx,
  input  wire win_entry_t      rd_entry,
  output logic                 found_r,
  output logic [IDXW-1:0]      hit_idx_r,
  output logic [TIME_W-1:0]    hit_time_r
);

  logic signed [LEVEL_W-1:0]  prev_level_r;
  logic signed [SCALED_W-1:0] cur_scaled;
  logic signed [SCALED_W-1:0] prev_scaled;
  logic                       rise;

  always_comb begin
    cur_scaled  = SCALED_W'($signed(rd_entry.level)) * RISE_NUM;
    prev_scaled = SCALED_W'(prev_level_r) * RISE_DEN;
    rise        = (rd_idx != '0) && (cur_scaled >= prev_scaled);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (start) begin
      found_r <= 1'b0;
    end else if (rd_valid && rise) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      prev_level_r <= rd_entry.level;
      if (rise) begin
        hit_idx_r  <= rd_idx;
        hit_time_r <= rd_entry.tstamp;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/peak_rr_interval_detector.sv -----
// Top level of the peak RR interval detector.
// One sample is taken per transaction and exactly one result follows it. The
// window of the newest 2*WINDOW_HALF samples lives in a single-port-read RAM
// used as a ring buffer. A sample at or below the threshold goes straight to
// emit; one above it first passes the scan state, where the rising-edge search
// walks the RAM read port one entry per cycle over the n window entries (at
// most 2*WINDOW_HALF). A new sample is taken while the previous result still
// waits in the output register. No clearing pass is needed after reset.
`default_nettype none

module peak_rr_interval_detector
  import prr_pkg::*;
#(
  parameter int WINDOW_HALF = 5
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // sample_time [30:0], potential [46:31]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // peak_index [4:0], rr_interval [36:5]
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // index_valid [0], rr_valid [1]
  output logic [OUT_USER_W-1:0]      out_tuser,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data
);

  localparam int DEPTH = 2 * WINDOW_HALF;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [1:0]                state_r, state_nxt;
  logic [CFG_W-1:0]          refractory_r;
  logic signed [LEVEL_W-1:0] threshold_r;
  logic [AW-1:0]             head_r, wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]             cnt_r, n_r, iss_k_r;
  logic                      above_r;
  logic                      rd_valid_r;
  logic [AW-1:0]             rd_idx_r;
  logic signed [AW:0]        held_r;
  logic signed [RR_W-1:0]    last_peak_r;
  logic                      out_valid_r;
  logic [OUT_DATA_W-1:0]     out_data_r;
  logic [OUT_USER_W-1:0]     out_user_r;

  win_entry_t                in_entry;
  win_entry_t                rd_entry;
  logic                      accept, full, rd_en, scan_last, emit_go;
  logic [AW-1:0]             head_nxt;
  logic                      found;
  logic [AW-1:0]             hit_idx;
  logic [TIME_W-1:0]         hit_time;
  logic signed [AW:0]        held_sel;
  logic signed [RR_W-1:0]    held_ext;
  logic signed [RR_W:0]      diff;
  logic                      rr_ok;

  assign in_entry.tstamp = in_tdata[TIME_W-1:0];
  assign in_entry.level  = in_tdata[TIME_W+LEVEL_W-1:TIME_W];

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign full       = (cnt_r == CW'(DEPTH));
  assign head_nxt   = full ? ptr_inc(head_r) : head_r;
  assign rd_en      = (state_r == ST_SCAN) && (iss_k_r < n_r);
  assign scan_last  = rd_valid_r && (rd_idx_r == AW'(n_r - 1'b1));
  assign emit_go    = (state_r == ST_EMIT) && (!out_valid_r || out_tready);

  prr_win_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk       (clk),
    .wr_en     (accept),
    .wr_addr   (wr_ptr_r),
    .wr_data   (in_entry),
    .rd_en     (rd_en),
    .rd_addr   (rd_ptr_r),
    .rd_data_r (rd_entry)
  );

  prr_rise_scan #(.IDXW(AW)) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (accept),
    .rd_valid   (rd_valid_r),
    .rd_idx     (rd_idx_r),
    .rd_entry   (rd_entry),
    .found_r    (found),
    .hit_idx_r  (hit_idx),
    .hit_time_r (hit_time)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ($signed(in_entry.level) > threshold_r) ? ST_SCAN : ST_EMIT;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    held_sel = found ? $signed({1'b0, hit_idx}) : held_r;
    held_ext = RR_W'(held_sel);
    diff     = $signed({2'b00, hit_time}) - (RR_W + 1)'(last_peak_r);
    rr_ok    = found && (hit_idx == AW'(WINDOW_HALF)) && (hit_time != '0) &&
               (diff > $signed({(RR_W + 1 - CFG_W)'(0), refractory_r}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      refractory_r <= REFRACTORY_RESET;
      threshold_r  <= THRESHOLD_RESET;
      head_r       <= '0;
      wr_ptr_r     <= '0;
      cnt_r        <= '0;
      rd_valid_r   <= 1'b0;
      held_r       <= '1;
      last_peak_r  <= '1;
      out_valid_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_valid_r <= rd_en;
      if (cfg_we) begin
        case (cfg_index)
          REG_REFRACTORY: refractory_r <= cfg_data;
          REG_THRESHOLD:  threshold_r  <= $signed(cfg_data);
          default: ;
        endcase
      end
      if (accept) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
        head_r   <= head_nxt;
        if (!full) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (emit_go) begin
        out_valid_r <= 1'b1;
        if (above_r) begin
          held_r <= held_sel;
          if (rr_ok) begin
            last_peak_r <= $signed({1'b0, hit_time});
          end
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      above_r <= ($signed(in_entry.level) > threshold_r);
      n_r     <= full ? CW'(DEPTH) : cnt_r + 1'b1;
      rd_ptr_r <= head_nxt;
      iss_k_r <= '0;
    end else if (rd_en) begin
      rd_ptr_r <= ptr_inc(rd_ptr_r);
      iss_k_r  <= iss_k_r + 1'b1;
    end
    if (rd_en) begin
      rd_idx_r <= iss_k_r[AW-1:0];
    end
    if (emit_go) begin
      if (above_r) begin
        out_user_r <= {rr_ok, 1'b1};
        out_data_r <= {(OUT_DATA_W - RR_W - PIDX_W)'(0),
                       rr_ok ? diff[RR_W-1:0] : RR_W'(0),
                       held_ext[PIDX_W-1:0]};
      end else begin
        out_user_r <= '0;
        out_data_r <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

// ----- hw/rtl/prr_checker.sv -----
// Port-level checks of the peak RR interval detector and their binding.
`default_nettype none

module prr_checker
  import prr_pkg::*;
#(
  parameter int WINDOW_HALF = 5
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic [OUT_USER_W-1:0] out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("Result changed while stalled.");

  a_rr_needs_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0] &&
      (out_tdata[PIDX_W-1:0] == PIDX_W'(WINDOW_HALF)) &&
      (out_tdata[PIDX_W+RR_W-1:PIDX_W] != '0))
    else $error("Interval reported without a peak at the window center.");

  a_quiet_below: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> (out_tdata == '0) && !out_tuser[1])
    else $error("Below-threshold result is not all zero.");

  a_no_rr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> (out_tdata[PIDX_W+RR_W-1:PIDX_W] == '0))
    else $error("Interval field set without a valid interval.");

endmodule

bind peak_rr_interval_detector prr_checker #(.WINDOW_HALF(WINDOW_HALF)) u_prr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ----- test/peak_rr_interval_detector_tb.sv -----
// Self-checking testbench of the peak RR interval detector: directed and random samples.
`timescale 1ns / 1ps

module peak_rr_interval_detector_tb
  import prr_pkg::*;
();

  localparam int WIN_HALF   = 5;
  localparam int WIN_DEPTH  = 2 * WIN_HALF;
  localparam int CYCLE_CAP  = 400000;
  localparam int QUIET_WAIT = 20;
  localparam int RANDOM_ITEMS = 400;
  localparam int EXP_DEPTH  = 1024;

  typedef struct {
    logic              index_valid;
    logic [PIDX_W-1:0] peak_index;
    logic              rr_valid;
    logic [RR_W-1:0]   rr_interval;
  } rr_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_REFRACTORY;
  logic [CFG_W-1:0] cfg_data = '0;

  // Predictor state and register copies.
  logic [TIME_W-1:0]         win_time [WIN_DEPTH];
  logic signed [LEVEL_W-1:0] win_level [WIN_DEPTH];
  int                        win_fill;
  int                        held_index;
  longint                    last_peak;
  logic [CFG_W-1:0]          refractory;
  logic signed [LEVEL_W-1:0] threshold;

  rr_result_t expected_buf [EXP_DEPTH];
  int         exp_wr_cnt = 0;
  int         exp_rd_cnt = 0;
  int         mismatches = 0;
  int         samples_sent = 0;
  int         cycle_count = 0;
  bit         idle_en = 1'b0;
  int         ready_stall = 0;
  longint     beat_clock = 0;

  peak_rr_interval_detector #(
    .WINDOW_HALF(WIN_HALF)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_CAP) begin
      $display("peak_rr_interval_detector_tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (ready_stall != 0) begin
      ready_stall <= ready_stall - 1;
      out_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      ready_stall <= $urandom_range(0, 8);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic report_mismatch(string field, longint want, longint got);
    if (mismatches < 50)
      $display("mismatch in %s: expected %0d, got %0d", field, want, got);
    mismatches++;
  endtask

  function automatic void reset_predictor();
    win_fill = 0;
    held_index = -1;
    last_peak = -1;
    refractory = REFRACTORY_RESET;
    threshold = THRESHOLD_RESET;
  endfunction

  function automatic rr_result_t predict_sample(logic [TIME_W-1:0] t,
                                                logic signed [LEVEL_W-1:0] p);
    rr_result_t r;
    bit found;
    longint found_time;
    longint cur;
    longint prv;
    r = '{1'b0, '0, 1'b0, '0};
    found = 1'b0;
    found_time = -1;
    if (win_fill < WIN_DEPTH) begin
      win_time[win_fill] = t;
      win_level[win_fill] = p;
      win_fill++;
    end else begin
      for (int i = 1; i < WIN_DEPTH; i++) begin
        win_time[i-1] = win_time[i];
        win_level[i-1] = win_level[i];
      end
      win_time[WIN_DEPTH-1] = t;
      win_level[WIN_DEPTH-1] = p;
    end
    if (p > threshold) begin
      for (int i = 1; i < win_fill; i++) begin
        cur = longint'(win_level[i]) * 1000;
        prv = longint'(win_level[i-1]) * 1001;
        if (cur >= prv) begin
          held_index = i;
          found = 1'b1;
          found_time = longint'(win_time[i]);
        end
      end
      if (found && held_index == WIN_HALF && found_time > 0 &&
          found_time - last_peak > longint'(refractory)) begin
        r.rr_valid = 1'b1;
        r.rr_interval = RR_W'(found_time - last_peak);
        last_peak = found_time;
      end
      r.index_valid = 1'b1;
      r.peak_index = PIDX_W'(held_index);
    end
    return r;
  endfunction

  always @(posedge clk) begin : check_results
    rr_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (exp_rd_cnt == exp_wr_cnt) begin
        report_mismatch("unexpected result", 0, 1);
      end else begin
        want = expected_buf[exp_rd_cnt % EXP_DEPTH];
        exp_rd_cnt++;
        if (out_tuser[0] !== want.index_valid)
          report_mismatch("index_valid", want.index_valid, out_tuser[0]);
        if (out_tdata[4:0] !== want.peak_index)
          report_mismatch("peak_index", want.peak_index, out_tdata[4:0]);
        if (out_tuser[1] !== want.rr_valid)
          report_mismatch("rr_valid", want.rr_valid, out_tuser[1]);
        if (out_tdata[36:5] !== want.rr_interval)
          report_mismatch("rr_interval", want.rr_interval, out_tdata[36:5]);
      end
    end
  end

  task automatic send_sample(logic [TIME_W-1:0] t, logic signed [LEVEL_W-1:0] p);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tdata <= {1'b0, p, t};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    expected_buf[exp_wr_cnt % EXP_DEPTH] = predict_sample(t, p);
    exp_wr_cnt++;
    samples_sent++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (exp_wr_cnt != exp_rd_cnt) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    if (idx == REG_REFRACTORY)
      refractory = value;
    else if (idx == REG_THRESHOLD)
      threshold = value;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // A rising run followed by a falling run; four falling samples put the peak
  // at the middle of a full window.
  task automatic send_beat(int step, int rise_len, int fall_len, int lo, int peak);
    int lvl;
    for (int k = 1; k <= rise_len; k++) begin
      lvl = lo + (peak - lo) * k / rise_len;
      send_sample(TIME_W'(beat_clock), LEVEL_W'(lvl));
      beat_clock += step;
    end
    for (int k = 1; k <= fall_len; k++) begin
      lvl = peak - (peak - lo) * k / (fall_len + 1);
      send_sample(TIME_W'(beat_clock), LEVEL_W'(lvl));
      beat_clock += step;
    end
  endtask

  task automatic test_field_extremes();
    send_sample(31'd0, -16'sd32768);
    send_sample(31'h7FFF_FFFF, 16'sd32767);
    send_sample(31'h2AAA_AAAA, 16'sh5555);
    send_sample(31'h5555_5555, 16'shAAAA);
  endtask

  task automatic test_first_peak();
    beat_clock = 1000;
    send_beat(1, 6, 4, 2000, 12000);
  endtask

  task automatic test_time_backwards();
    beat_clock = 200;
    send_beat(1, 6, 4, 2000, 12000);
  endtask

  task automatic test_register_extremes();
    write_register(REG_REFRACTORY, 16'd0);
    write_register(REG_THRESHOLD, 16'h8000);
    beat_clock = 0;
    send_beat(0, 6, 4, -3000, 5000);
    beat_clock = 5000;
    send_beat(1, 6, 4, -3000, 5000);
    send_beat(1, 6, 4, -32768, 32767);
    write_register(REG_THRESHOLD, 16'h7FFF);
    send_beat(3, 6, 4, 0, 32767);
    write_register(REG_REFRACTORY, 16'hFFFF);
    write_register(REG_THRESHOLD, THRESHOLD_RESET);
    send_beat(7, 6, 4, 1500, 20000);
    beat_clock += 70000;
    send_beat(7, 6, 4, 1500, 20000);
  endtask

  task automatic test_random_traffic();
    int start;
    int peak;
    int lo;
    int step;
    start = samples_sent;
    while (samples_sent - start < RANDOM_ITEMS) begin
      if (samples_sent - start >= RANDOM_ITEMS - 40)
        idle_en = 1'b0;
      else if ($urandom_range(0, 9) == 0)
        idle_en = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 24) == 0) begin
        case ($urandom_range(0, 3))
          0: write_register(REG_REFRACTORY, 16'd0);
          1: write_register(REG_REFRACTORY, 16'hFFFF);
          2: write_register(REG_REFRACTORY, CFG_W'($urandom_range(0, 200)));
          default: write_register(REG_REFRACTORY, CFG_W'($urandom));
        endcase
        case ($urandom_range(0, 4))
          0: write_register(REG_THRESHOLD, 16'h8000);
          1: write_register(REG_THRESHOLD, 16'h7FFF);
          2: write_register(REG_THRESHOLD, CFG_W'($urandom));
          default: write_register(REG_THRESHOLD, THRESHOLD_RESET);
        endcase
      end
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 9))
          0: beat_clock = 0;
          1: beat_clock = longint'($urandom_range(0, 32'h7FFF_FFFF));
          2: beat_clock -= $urandom_range(1, 500);
          default: beat_clock += $urandom_range(0, 300);
        endcase
        if (beat_clock < 0)
          beat_clock = 0;
        beat_clock &= 64'h7FFF_FFFF;
        step = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 40);
        peak = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) - 32768
                                           : $urandom_range(1500, 32767);
        lo = peak - $urandom_range(1, 65535);
        if (lo < -32768)
          lo = -32768;
        send_beat(step, $urandom_range(1, 7),
                  ($urandom_range(0, 4) < 3) ? 4 : $urandom_range(1, 5), lo, peak);
      end else begin
        repeat ($urandom_range(1, 4))
          send_sample(TIME_W'($urandom), LEVEL_W'($urandom));
      end
    end
  endtask

  initial begin
    reset_predictor();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_en = 1'b1;
    test_field_extremes();
    test_first_peak();
    test_time_backwards();
    test_register_extremes();
    test_random_traffic();
    wait_idle();
    repeat (QUIET_WAIT) @(posedge clk);
    if (mismatches == 0 && exp_wr_cnt == exp_rd_cnt) begin
      $display("peak_rr_interval_detector_tb: clean");
    end else begin
      $display("peak_rr_interval_detector_tb: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/prr_pkg.sv
hw/rtl/prr_win_ram.sv
hw/rtl/prr_rise_scan.sv
hw/rtl/peak_rr_interval_detector.sv
hw/rtl/prr_checker.sv
test/peak_rr_interval_detector_tb.sv
